// File: hw/rtl/signed_int_to_seven_segment_writes_assert.svh
// assertion macros used by the display write sequencer datapath
`ifndef SIGNED_INT_TO_SEVEN_SEGMENT_WRITES_ASSERT_SVH
`define SIGNED_INT_TO_SEVEN_SEGMENT_WRITES_ASSERT_SVH

// same-cycle implication, checked out of reset
`define S7W_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define S7W_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/s7w_pkg.sv
// shared types, constants and the segment lookup for the display write sequencer
`timescale 1ns / 1ps

package s7w_pkg;

	// display size and field widths
	localparam int NUM_DIGITS = 8;
	localparam int VALUE_W    = 28;
	localparam int MAG_W      = 28;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 8;
	localparam int DIGIT_W    = 4;
	// most digits a 28-bit magnitude can have (2^27 has nine)
	localparam int MAX_DIG    = 9;
	localparam int CNT_W      = $clog2(MAX_DIG + 1);
	localparam int POS_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	// overflow thresholds on the magnitude
	localparam longint unsigned LIM_ALL = 10 ** NUM_DIGITS;
	localparam longint unsigned LIM_NEG = 10 ** (NUM_DIGITS - 1);

	// divide by ten as multiply by reciprocal, exact for any 32-bit value
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          PROD_W      = MAG_W + 32;

	// configuration register indexes and address width
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_PAT03 = 2'd0;
	localparam logic [1:0] REG_PAT47 = 2'd1;
	localparam logic [1:0] REG_PAT89 = 2'd2;
	localparam logic [1:0] REG_DASH  = 2'd3;

	// reset values of the pattern registers
	localparam logic [31:0] RST_PAT03 = 32'h796D_307E;
	localparam logic [31:0] RST_PAT47 = 32'h705F_5B33;
	localparam logic [15:0] RST_PAT89 = 16'h7B7F;
	localparam logic [7:0]  RST_DASH  = 8'h01;

	// kinds of write the controller can ask for
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DIGIT = 2'd1;
	localparam logic [1:0] KIND_DASH  = 2'd2;

	typedef struct packed {
		logic             start;
		logic             load;
		logic [1:0]       kind;
		logic [POS_W-1:0] pos;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic             ext_done;
		logic             out_free;
		logic [CNT_W-1:0] ndig;
		logic             dash;
	} dp_stat_t;

	// segment byte for one decimal digit
	function automatic logic [DATA_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit,
		input logic [31:0] p03, input logic [31:0] p47, input logic [15:0] p89);
		logic [DATA_W-1:0] seg;
		case (digit)
			4'd0:    seg = p03[7:0];
			4'd1:    seg = p03[15:8];
			4'd2:    seg = p03[23:16];
			4'd3:    seg = p03[31:24];
			4'd4:    seg = p47[7:0];
			4'd5:    seg = p47[15:8];
			4'd6:    seg = p47[23:16];
			4'd7:    seg = p47[31:24];
			4'd8:    seg = p89[7:0];
			4'd9:    seg = p89[15:8];
			default: seg = '0;
		endcase
		return seg;
	endfunction

endpackage

// File: hw/rtl/s7w_regs.sv
// apb configuration registers holding the segment patterns
`timescale 1ns / 1ps

module s7w_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [s7w_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [31:0]                 pat03,
	output logic [31:0]                 pat47,
	output logic [15:0]                 pat89,
	output logic [7:0]                  dash_pat
);
	import s7w_pkg::*;

	logic [31:0] pat03_q;
	logic [31:0] pat47_q;
	logic [15:0] pat89_q;
	logic [7:0]  dash_q;
	logic        wr_en;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat03_q <= RST_PAT03;
			pat47_q <= RST_PAT47;
			pat89_q <= RST_PAT89;
			dash_q  <= RST_DASH;
		end else if (wr_en) begin
			case (idx)
				REG_PAT03: pat03_q <= pwdata;
				REG_PAT47: pat47_q <= pwdata;
				REG_PAT89: pat89_q <= pwdata[15:0];
				REG_DASH:  dash_q  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_PAT03: prdata = pat03_q;
			REG_PAT47: prdata = pat47_q;
			REG_PAT89: prdata = {16'd0, pat89_q};
			REG_DASH:  prdata = {24'd0, dash_q};
			default:   prdata = '0;
		endcase
	end

	assign pat03    = pat03_q;
	assign pat47    = pat47_q;
	assign pat89    = pat89_q;
	assign dash_pat = dash_q;

endmodule

// File: hw/rtl/s7w_ctrl.sv
// controller that orders the clear, digit and dash writes of one item
`timescale 1ns / 1ps

module s7w_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  s7w_pkg::dp_stat_t stat,
	output s7w_pkg::dp_cmd_t  cmd
);
	import s7w_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_DIGIT = 2'd2;
	localparam logic [1:0] ST_DASH  = 2'd3;

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic [CNT_W-1:0] shown;
	logic             top_digit;

	assign in_ready = (state_q == ST_IDLE);

	// digits actually written and whether pos is the top one
	assign shown     = (stat.ndig > CNT_W'(NUM_DIGITS)) ? CNT_W'(NUM_DIGITS) : stat.ndig;
	assign top_digit = ((CNT_W'(pos_q) + CNT_W'(1)) == shown);

	// next state and command
	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		cmd       = '0;
		cmd.pos   = pos_q;
		cmd.start = in_valid & in_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CLEAR;
					pos_d   = '0;
				end
			end
			ST_CLEAR: begin
				cmd.kind = KIND_CLEAR;
				if (stat.out_free) begin
					cmd.load = 1'b1;
					if (pos_q == POS_W'(NUM_DIGITS - 1)) begin
						state_d = ST_DIGIT;
						pos_d   = '0;
					end else begin
						pos_d = pos_q + POS_W'(1);
					end
				end
			end
			ST_DIGIT: begin
				cmd.kind = KIND_DIGIT;
				cmd.last = top_digit & ~stat.dash;
				if (stat.out_free && stat.ext_done) begin
					cmd.load = 1'b1;
					if (top_digit) begin
						state_d = stat.dash ? ST_DASH : ST_IDLE;
					end else begin
						pos_d = pos_q + POS_W'(1);
					end
				end
			end
			ST_DASH: begin
				cmd.kind = KIND_DASH;
				cmd.last = 1'b1;
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

endmodule

// File: hw/rtl/s7w_dp.sv
// datapath: digit extraction, digit store and the output register
`timescale 1ns / 1ps
`include "signed_int_to_seven_segment_writes_assert.svh"

module s7w_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [s7w_pkg::VALUE_W-1:0] value,
	input  logic [31:0]                 pat03,
	input  logic [31:0]                 pat47,
	input  logic [15:0]                 pat89,
	input  logic [7:0]                  dash_pat,
	input  s7w_pkg::dp_cmd_t            cmd,
	output s7w_pkg::dp_stat_t           stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [s7w_pkg::ADDR_W-1:0]  reg_address,
	output logic [s7w_pkg::DATA_W-1:0]  reg_data,
	output logic                        last,
	output logic                        overflow
);
	import s7w_pkg::*;

	logic [MAG_W-1:0]   mag_in;
	logic               ovf_in;
	logic [MAG_W-1:0]   mag_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               neg_q;
	logic               ovf_q;
	logic [DIGIT_W-1:0] digit_q [NUM_DIGITS];
	logic [PROD_W-1:0]  prod;
	logic [MAG_W-1:0]   quot;
	logic [DIGIT_W-1:0] rem;
	logic               out_valid_q;
	logic               out_free;
	logic [ADDR_W-1:0]  addr_q;
	logic [DATA_W-1:0]  data_q;
	logic               last_q;
	logic               ovf_out_q;
	logic [ADDR_W-1:0]  addr_d;
	logic [DATA_W-1:0]  data_d;

	// magnitude of the incoming item, exact for the most negative value
	assign mag_in = value[VALUE_W-1] ? MAG_W'(~value + VALUE_W'(1)) : MAG_W'(value);
	// too many positions: more digits than the display, or no room for the dash
	assign ovf_in = (64'(mag_in) >= 64'(LIM_ALL)) |
		(value[VALUE_W-1] & (64'(mag_in) >= 64'(LIM_NEG)));

	// one decimal digit per cycle
	assign prod = PROD_W'(mag_q) * PROD_W'(RECIP10);
	assign quot = MAG_W'(prod >> RECIP_SHIFT);
	assign rem  = DIGIT_W'(mag_q - ((quot << 3) + (quot << 1)));

	// extraction control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (quot == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// extraction payload and digit store
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mag_q <= mag_in;
			neg_q <= value[VALUE_W-1];
			ovf_q <= ovf_in;
		end else if (busy_q) begin
			mag_q <= quot;
			if (cnt_q < CNT_W'(NUM_DIGITS)) begin
				digit_q[cnt_q[POS_W-1:0]] <= rem;
			end
		end
	end

	assign out_free      = ~out_valid_q | out_ready;
	assign stat.ext_done = ~busy_q;
	assign stat.out_free = out_free;
	assign stat.ndig     = cnt_q;
	assign stat.dash     = neg_q & ~ovf_q;

	// payload of the requested write
	always_comb begin
		case (cmd.kind)
			KIND_CLEAR: begin
				addr_d = ADDR_W'(cmd.pos) + ADDR_W'(1);
				data_d = '0;
			end
			KIND_DIGIT: begin
				addr_d = ADDR_W'(cmd.pos) + ADDR_W'(1);
				data_d = seg_of(digit_q[cmd.pos], pat03, pat47, pat89);
			end
			KIND_DASH: begin
				addr_d = ADDR_W'(cnt_q) + ADDR_W'(1);
				data_d = dash_pat;
			end
			default: begin
				addr_d = '0;
				data_d = '0;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q    <= addr_d;
			data_q    <= data_d;
			last_q    <= cmd.last;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign reg_address = addr_q;
	assign reg_data    = data_q;
	assign last        = last_q;
	assign overflow    = ovf_out_q;

	`S7W_ASSERT_NOW(a_load_when_free, cmd.load, out_free, "write loaded over an untaken item")
	`S7W_ASSERT_NOW(a_digit_after_ext, cmd.load && (cmd.kind == KIND_DIGIT), !busy_q,
		"digit written before extraction finished")
	`S7W_ASSERT_NOW(a_no_dash_on_ovf, cmd.load && (cmd.kind == KIND_DASH), !ovf_q,
		"dash written on an overflowed item")
	`S7W_ASSERT_NEXT(a_start_busy, cmd.start, busy_q, "extraction did not start")

endmodule

// File: hw/rtl/signed_int_to_seven_segment_writes.sv
// Top level of the seven-segment display write sequencer.
// One input item (value, signed 28 bits) enters on in_valid/in_ready and
// becomes a sequence of display register writes on out_valid/out_ready, each
// item carrying reg_address, reg_data, last and overflow.
// Each value gives eight clears (addresses 1..8, data 0), then one write per
// shown digit from least significant up, then a dash write when negative and
// not overflowed; last marks the final write of the sequence.
// After accept the controller enters its clear state and loads the first write.
// Throughput: one write per cycle while out_ready is high; a value gives
// 9 to 16 writes. Digit extraction runs one digit per cycle on a reciprocal
// multiplier during the clears; the first digit write waits until extraction
// has finished, which for nine-digit magnitudes can outlast the clears.
// in_ready is high only between sequences, including while the final write
// still waits in the output register. A stall on out_ready holds that register
// and pauses the sequence; nothing is lost or repeated.
// Reset clears the controller and output valid and restores the default
// segment patterns; the pattern registers sit on an APB port (pready always 1)
// and the user must write them only while the block is idle (not enforced).
`timescale 1ns / 1ps

module signed_int_to_seven_segment_writes (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [s7w_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [s7w_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [s7w_pkg::ADDR_W-1:0]  reg_address,
	output logic [s7w_pkg::DATA_W-1:0]  reg_data,
	output logic                        last,
	output logic                        overflow
);
	import s7w_pkg::*;

	logic [31:0] pat03;
	logic [31:0] pat47;
	logic [15:0] pat89;
	logic [7:0]  dash_pat;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	// configuration registers
	s7w_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pat03    (pat03),
		.pat47    (pat47),
		.pat89    (pat89),
		.dash_pat (dash_pat)
	);

	// sequencing controller
	s7w_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	s7w_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.pat03       (pat03),
		.pat47       (pat47),
		.pat89       (pat89),
		.dash_pat    (dash_pat),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.last        (last),
		.overflow    (overflow)
	);

endmodule
